// ===== src/sla_pkg.sv =====
`timescale 1ns / 1ps

package sla_pkg;

   localparam int TAG_W   = 16;
   localparam int SIZE_W  = 20;
   localparam int TIME_W  = 32;
   localparam int ORDER_W = 6;
   localparam int CAP_W   = 20;
   localparam int BYTES_W = 40;
   localparam int FREE_W  = 25;

   localparam logic [CAP_W-1:0] CAP_RESET = 20'd9999;
   localparam int FREE_MIN = -16777215;
   localparam int FREE_MAX = 1048575;

   typedef enum logic [1:0] {
      FN_ADMIT = 2'd0,
      FN_ADD   = 2'd1,
      FN_TOUCH = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      ST_EVICTED   = 3'd0,
      ST_ADMITTED  = 3'd1,
      ST_TOO_BIG   = 3'd2,
      ST_NO_VICTIM = 3'd3,
      ST_ADDED     = 3'd4,
      ST_FULL      = 3'd5,
      ST_TOUCHED   = 3'd6,
      ST_ABSENT    = 3'd7
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ADMIT,
      S_FIT,
      S_VSCAN,
      S_VDONE,
      S_DSCAN,
      S_INSERT,
      S_TSCAN,
      S_TDONE
   } state_type;

   typedef struct packed {
      logic [TAG_W-1:0]   tag;
      logic [SIZE_W-1:0]  size_mb;
      logic [TIME_W-1:0]  time_s;
      logic [ORDER_W-1:0] order;
   } entry_type;

endpackage

// ===== src/sla_entry_mem.sv =====
`timescale 1ns / 1ps

module sla_entry_mem
   import sla_pkg::*;
#(
   parameter int ENTRIES = 16,
   parameter int IW = 4
) (
   input  logic            clock,
   input  logic [IW-1:0]   rd_addr,
   output entry_type       rd_data,
   input  logic            wr_en,
   input  logic [IW-1:0]   wr_addr,
   input  entry_type       wr_data
);

   entry_type mem [ENTRIES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/size_aware_lru_admission.sv =====
`timescale 1ns / 1ps

// Size-aware LRU admission table. Entries (tag, size in MB, time, insertion
// rank) sit in a synchronous memory; valid bits and the used-MB total are
// flops. A word is taken only when the block is idle. Admit checks the size
// against capacity, then evicts the oldest eligible entry (time <= now,
// ties to smaller size, then earlier insertion) until the object fits,
// emitting one result word per eviction, then inserts; with no victim left
// it stops. Each eviction costs two full memory sweeps (victim search,
// rank fixup). An output stall holds the block in the state that emits a
// result. Capacity is written through the APB port at any address with
// paddr[2] low. No clearing pass is needed after reset.

module size_aware_lru_admission
   import sla_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_func,
   input  logic [TAG_W-1:0]         req_tag,
   input  logic [BYTES_W-1:0]       req_size_bytes,
   input  logic [TIME_W-1:0]        req_timestamp,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [2:0]               rsp_status,
   output logic [TAG_W-1:0]         rsp_result_tag,
   output logic [SIZE_W-1:0]        rsp_result_size_mb,
   output logic signed [FREE_W-1:0] rsp_free_mb,
   output logic                     rsp_last,
   // config port
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [2:0]               paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int SW = $clog2(ENTRIES + 1);      // scan counter, counts to ENTRIES
   localparam int UW = SIZE_W + SW;              // used MB never overflows
   localparam int FW = UW + 1;                   // signed free space

   state_type            state_ff, state_in;
   func_type             func_ff;
   logic [TAG_W-1:0]     tag_ff;
   logic [SIZE_W-1:0]    sz_ff;
   logic [TIME_W-1:0]    t_ff;
   logic [CAP_W-1:0]     cap_ff;
   logic [UW-1:0]        used_ff, used_in;
   logic [ENTRIES-1:0]   valid_ff, valid_in;

   // sweep pipeline: issue address, data arrives in the next cycle
   logic [SW-1:0]        sc_ff, sc_in;
   logic                 pv_ff, pv_in;
   logic [IW-1:0]        pidx_ff, pidx_in;
   logic                 found_ff, found_in;
   logic [IW-1:0]        bidx_ff, bidx_in;
   entry_type            best_ff, best_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, e_status;
   logic [TAG_W-1:0]     rsp_tag_ff, e_tag;
   logic [SIZE_W-1:0]    rsp_size_ff, e_size;
   logic signed [FREE_W-1:0] rsp_free_ff;
   logic                 rsp_last_ff, e_last;
   logic                 emit;

   logic                 rd_scan, issue, scan_done, out_free, accept, cfg_wr;
   logic                 better, has_slot;
   logic [IW-1:0]        slot;
   logic [SW-1:0]        cnt;
   logic                 wr_en;
   logic [IW-1:0]        wr_addr;
   entry_type            wr_data, rd_data;
   logic signed [31:0]   free_cur, free_next;

   function automatic logic signed [31:0] free_of(input logic [CAP_W-1:0] cap,
                                                  input logic [UW-1:0] used);
      logic signed [FW-1:0] f;
      logic signed [31:0]   w;
      f = $signed({{(FW-CAP_W){1'b0}}, cap}) - $signed({1'b0, used});
      w = 32'(f);
      if (w < FREE_MIN) w = FREE_MIN;
      if (w > FREE_MAX) w = FREE_MAX;
      return w;
   endfunction

   sla_entry_mem #(.ENTRIES(ENTRIES), .IW(IW)) u_mem (
      .clock   (clock),
      .rd_addr (sc_ff[IW-1:0]),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cfg_wr    = psel && penable && pwrite && !paddr[2];
   assign pready    = 1'b1;
   assign prdata    = paddr[2] ? 32'd0 : 32'(cap_ff);

   assign rd_scan   = (state_ff == S_VSCAN) || (state_ff == S_DSCAN) ||
                      (state_ff == S_TSCAN);
   assign issue     = rd_scan && (sc_ff != SW'(ENTRIES));
   assign scan_done = rd_scan && (sc_ff == SW'(ENTRIES)) && !pv_ff;

   assign free_cur  = free_of(cap_ff, used_ff);
   assign free_next = free_of(cap_ff, used_in);

   // victim ordering: earliest time, then smaller size, then earlier insert
   assign better = !found_ff ||
                   (rd_data.time_s < best_ff.time_s) ||
                   ((rd_data.time_s == best_ff.time_s) &&
                    ((rd_data.size_mb < best_ff.size_mb) ||
                     ((rd_data.size_mb == best_ff.size_mb) &&
                      (rd_data.order < best_ff.order))));

   // lowest free slot and occupancy
   always_comb begin
      slot     = '0;
      has_slot = 1'b0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            slot     = IW'(i);
            has_slot = 1'b1;
         end
      end
      cnt = SW'($countones(valid_ff));
   end

   always_comb begin
      state_in = state_ff;
      sc_in    = issue ? sc_ff + SW'(1) : sc_ff;
      pv_in    = issue;
      pidx_in  = sc_ff[IW-1:0];
      found_in = found_ff;
      bidx_in  = bidx_ff;
      best_in  = best_ff;
      used_in  = used_ff;
      valid_in = valid_ff;
      wr_en    = 1'b0;
      wr_addr  = pidx_ff;
      wr_data  = rd_data;
      emit     = 1'b0;
      e_status = ST_EVICTED;
      e_tag    = tag_ff;
      e_size   = sz_ff;
      e_last   = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               sc_in    = '0;
               pv_in    = 1'b0;
               found_in = 1'b0;
               case (req_func)
                  FN_ADMIT: state_in = S_ADMIT;
                  FN_ADD:   state_in = S_INSERT;
                  FN_TOUCH: state_in = S_TSCAN;
                  default:  state_in = S_IDLE;    // unknown code: dropped
               endcase
            end
         end
         S_ADMIT: begin
            if (sz_ff > cap_ff) begin
               if (out_free) begin
                  emit     = 1'b1;
                  e_status = ST_TOO_BIG;
                  state_in = S_IDLE;
               end
            end else begin
               state_in = S_FIT;
            end
         end
         S_FIT: begin
            if ($signed({12'd0, sz_ff}) > free_cur) begin
               state_in = S_VSCAN;
               sc_in    = '0;
               pv_in    = 1'b0;
               found_in = 1'b0;
            end else begin
               state_in = S_INSERT;
            end
         end
         S_VSCAN: begin
            if (pv_ff && valid_ff[pidx_ff] && (rd_data.time_s <= t_ff) && better) begin
               found_in = 1'b1;
               bidx_in  = pidx_ff;
               best_in  = rd_data;
            end
            if (scan_done) state_in = S_VDONE;
         end
         S_VDONE: begin
            if (out_free) begin
               emit = 1'b1;
               if (found_ff) begin
                  valid_in[bidx_ff] = 1'b0;
                  used_in  = used_ff - UW'(best_ff.size_mb);
                  e_status = ST_EVICTED;
                  e_tag    = best_ff.tag;
                  e_size   = best_ff.size_mb;
                  e_last   = 1'b0;
                  state_in = S_DSCAN;
                  sc_in    = '0;
                  pv_in    = 1'b0;
               end else begin
                  e_status = ST_NO_VICTIM;
                  state_in = S_IDLE;
               end
            end
         end
         S_DSCAN: begin
            // close the rank gap left by the victim
            if (pv_ff && valid_ff[pidx_ff] && (rd_data.order > best_ff.order)) begin
               wr_en         = 1'b1;
               wr_addr       = pidx_ff;
               wr_data       = rd_data;
               wr_data.order = rd_data.order - ORDER_W'(1);
            end
            if (scan_done) state_in = S_FIT;
         end
         S_INSERT: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
               if (has_slot) begin
                  wr_en           = 1'b1;
                  wr_addr         = slot;
                  wr_data.tag     = tag_ff;
                  wr_data.size_mb = sz_ff;
                  wr_data.time_s  = t_ff;
                  wr_data.order   = ORDER_W'(cnt);
                  valid_in[slot]  = 1'b1;
                  used_in         = used_ff + UW'(sz_ff);
                  e_status        = (func_ff == FN_ADMIT) ? ST_ADMITTED : ST_ADDED;
               end else begin
                  e_status = ST_FULL;
               end
            end
         end
         S_TSCAN: begin
            if (pv_ff && !found_ff && valid_ff[pidx_ff] && (rd_data.tag == tag_ff)) begin
               found_in = 1'b1;
               bidx_in  = pidx_ff;
               best_in  = rd_data;
            end
            if (scan_done) state_in = S_TDONE;
         end
         S_TDONE: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
               if (found_ff) begin
                  wr_en          = 1'b1;
                  wr_addr        = bidx_ff;
                  wr_data        = best_ff;
                  wr_data.time_s = t_ff;
                  e_status       = ST_TOUCHED;
                  e_size         = best_ff.size_mb;
               end else begin
                  e_status = ST_ABSENT;
                  e_size   = '0;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (emit) rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_ff       <= CAP_RESET;
         used_ff      <= '0;
         valid_ff     <= '0;
         sc_ff        <= '0;
         pv_ff        <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         valid_ff     <= valid_in;
         sc_ff        <= sc_in;
         pv_ff        <= pv_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cfg_wr) cap_ff <= pwdata[CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff <= pidx_in;
      bidx_ff <= bidx_in;
      best_ff <= best_in;
      if (accept) begin
         func_ff <= func_type'(req_func);
         tag_ff  <= req_tag;
         sz_ff   <= req_size_bytes[BYTES_W-1:BYTES_W-SIZE_W];
         t_ff    <= req_timestamp;
      end
      if (emit) begin
         rsp_status_ff <= e_status;
         rsp_tag_ff    <= e_tag;
         rsp_size_ff   <= e_size;
         rsp_free_ff   <= free_next[FREE_W-1:0];
         rsp_last_ff   <= e_last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_result_tag     = rsp_tag_ff;
   assign rsp_result_size_mb = rsp_size_ff;
   assign rsp_free_mb        = rsp_free_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

// ===== src/sla_checker.sv =====
`timescale 1ns / 1ps

module sla_checker
   import sla_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic [2:0]               rsp_status,
   input logic [TAG_W-1:0]         rsp_result_tag,
   input logic [SIZE_W-1:0]        rsp_result_size_mb,
   input logic signed [FREE_W-1:0] rsp_free_mb,
   input logic                     rsp_last
);

   // held word stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_result_tag) && $stable(rsp_result_size_mb) &&
      $stable(rsp_free_mb) && $stable(rsp_last))
      else $error("result word changed while stalled");

   // only evictions are non-final
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status == ST_EVICTED) == !rsp_last))
      else $error("last flag does not match status");

   // a pending eviction means the request is still in progress
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("request taken before final result");

   // after an eviction is taken, more results follow, so still busy
   a_more: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last && !rsp_stall |=> req_stall)
      else $error("block went idle after a non-final result");

endmodule

bind size_aware_lru_admission sla_checker u_sla_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_status         (rsp_status),
   .rsp_result_tag     (rsp_result_tag),
   .rsp_result_size_mb (rsp_result_size_mb),
   .rsp_free_mb        (rsp_free_mb),
   .rsp_last           (rsp_last)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import sla_pkg::*;

   // reserved function code: the block drops it without a result
   localparam logic [1:0] FN_RSVD  = 2'd3;
   localparam logic [2:0] ADDR_CAP = 3'd0;
   localparam int         SLOTS    = 16;
   localparam int         CYCLE_LIMIT = 2000000;
   // quiet time after the last result before touching capacity
   localparam int         SETTLE   = 60;

   typedef struct {
      logic [1:0]         func;
      logic [TAG_W-1:0]   tag;
      logic [BYTES_W-1:0] bytes;
      logic [TIME_W-1:0]  stamp;
   } req_word_type;

   typedef struct {
      status_type                st;
      logic [TAG_W-1:0]          tag;
      logic [SIZE_W-1:0]         mb;
      logic signed [FREE_W-1:0]  free;
      logic                      last;
   } rsp_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [1:0]               req_func = FN_ADMIT;
   logic [TAG_W-1:0]         req_tag = '0;
   logic [BYTES_W-1:0]       req_size_bytes = '0;
   logic [TIME_W-1:0]        req_timestamp = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [2:0]               rsp_status;
   logic [TAG_W-1:0]         rsp_result_tag;
   logic [SIZE_W-1:0]        rsp_result_size_mb;
   logic signed [FREE_W-1:0] rsp_free_mb;
   logic                     rsp_last;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [2:0]               paddr = ADDR_CAP;
   logic [31:0]              pwdata = '0;
   logic [31:0]              prdata;
   logic                     pready;

   size_aware_lru_admission uut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Shadow of the entry table, updated as each word is accepted
   // ---------------------------------------------------------------
   logic              tbl_live  [SLOTS];
   logic [TAG_W-1:0]  tbl_tag   [SLOTS];
   logic [SIZE_W-1:0] tbl_mb    [SLOTS];
   logic [TIME_W-1:0] tbl_stamp [SLOTS];
   int                tbl_rank  [SLOTS];
   longint            used_total;
   longint            cap_mb;

   req_word_type pending_words[$];
   rsp_word_type due_results[$];
   int           errors;

   function automatic void post_result(status_type st, logic [TAG_W-1:0] tag,
                                       logic [SIZE_W-1:0] mb, logic last);
      rsp_word_type r;
      longint       f;
      f = cap_mb - used_total;
      if (f < FREE_MIN) f = FREE_MIN;
      if (f > FREE_MAX) f = FREE_MAX;
      r.st = st; r.tag = tag; r.mb = mb; r.free = FREE_W'(f); r.last = last;
      due_results.push_back(r);
   endfunction

   // oldest eligible entry: earliest stamp <= now, then smaller size, then rank
   function automatic int pick_victim(logic [TIME_W-1:0] now);
      int best;
      best = -1;
      for (int i = 0; i < SLOTS; i++) begin
         if (!tbl_live[i] || tbl_stamp[i] > now) continue;
         if (best < 0 || tbl_stamp[i] < tbl_stamp[best] ||
             (tbl_stamp[i] == tbl_stamp[best] &&
              (tbl_mb[i] < tbl_mb[best] ||
               (tbl_mb[i] == tbl_mb[best] && tbl_rank[i] < tbl_rank[best]))))
            best = i;
      end
      return best;
   endfunction

   function automatic bit place_entry(logic [TAG_W-1:0] tag, logic [SIZE_W-1:0] mb,
                                      logic [TIME_W-1:0] stamp);
      int slot;
      int count;
      slot = -1;
      count = 0;
      for (int i = 0; i < SLOTS; i++) begin
         if (tbl_live[i]) count++;
         else if (slot < 0) slot = i;
      end
      if (slot < 0) return 1'b0;
      tbl_live[slot] = 1'b1;
      tbl_tag[slot] = tag;
      tbl_mb[slot] = mb;
      tbl_stamp[slot] = stamp;
      tbl_rank[slot] = count;
      used_total += mb;
      return 1'b1;
   endfunction

   function automatic void predict_admission(req_word_type w);
      logic [SIZE_W-1:0] mb;
      int                v;
      mb = w.bytes[BYTES_W-1:20];
      case (w.func)
         FN_ADMIT: begin
            if (mb > cap_mb) begin
               post_result(ST_TOO_BIG, w.tag, mb, 1'b1);
               return;
            end
            while (longint'(mb) > cap_mb - used_total) begin
               v = pick_victim(w.stamp);
               if (v < 0) begin
                  post_result(ST_NO_VICTIM, w.tag, mb, 1'b1);
                  return;
               end
               for (int i = 0; i < SLOTS; i++)
                  if (tbl_live[i] && tbl_rank[i] > tbl_rank[v]) tbl_rank[i]--;
               tbl_live[v] = 1'b0;
               used_total -= tbl_mb[v];
               post_result(ST_EVICTED, tbl_tag[v], tbl_mb[v], 1'b0);
            end
            if (place_entry(w.tag, mb, w.stamp)) post_result(ST_ADMITTED, w.tag, mb, 1'b1);
            else post_result(ST_FULL, w.tag, mb, 1'b1);
         end
         FN_ADD: begin
            if (place_entry(w.tag, mb, w.stamp)) post_result(ST_ADDED, w.tag, mb, 1'b1);
            else post_result(ST_FULL, w.tag, mb, 1'b1);
         end
         FN_TOUCH: begin
            // lowest matching slot wins when tags repeat
            for (int i = 0; i < SLOTS; i++) begin
               if (tbl_live[i] && tbl_tag[i] == w.tag) begin
                  tbl_stamp[i] = w.stamp;
                  post_result(ST_TOUCHED, w.tag, tbl_mb[i], 1'b1);
                  return;
               end
            end
            post_result(ST_ABSENT, w.tag, '0, 1'b1);
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Driver: one NBA per input per edge; payload frozen while stalled
   // ---------------------------------------------------------------
   req_word_type cur_word;
   int           req_gap = 0;
   bit           req_quiet = 1'b0;

   always @(posedge clock) begin
      logic fire;
      logic nv;
      fire = req_valid && !req_stall;
      nv = req_valid && !fire;
      if (reset) begin
         nv = 1'b0;
      end else begin
         if (fire) predict_admission(cur_word);
         if (!req_valid || fire) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_words.size() != 0) begin
               cur_word = pending_words.pop_front();
               req_func <= cur_word.func;
               req_tag <= cur_word.tag;
               req_size_bytes <= cur_word.bytes;
               req_timestamp <= cur_word.stamp;
               nv = 1'b1;
               if ($urandom_range(0, 29) == 0) req_quiet = !req_quiet;
               req_gap = req_quiet ? 0 : $urandom_range(0, 11);
            end
         end
      end
      req_valid <= nv;
   end

   // ---------------------------------------------------------------
   // Monitor: checks each result word against the oldest expectation
   // ---------------------------------------------------------------
   int rsp_hold = 0;
   bit rsp_quiet = 1'b0;

   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_results.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result: status %0d tag %h mb %0d free %0d last %0b",
                        rsp_status, rsp_result_tag, rsp_result_size_mb, rsp_free_mb,
                        rsp_last);
         end else begin
            e = due_results.pop_front();
            if (rsp_status !== e.st || rsp_result_tag !== e.tag ||
                rsp_result_size_mb !== e.mb || rsp_free_mb !== e.free ||
                rsp_last !== e.last) begin
               errors++;
               if (errors <= 10) begin
                  $display("mismatch: exp st %0d tag %h mb %0d free %0d last %0b",
                           e.st, e.tag, e.mb, e.free, e.last);
                  $display("          got st %0d tag %h mb %0d free %0d last %0b",
                           rsp_status, rsp_result_tag, rsp_result_size_mb,
                           rsp_free_mb, rsp_last);
               end
            end
         end
         if ($urandom_range(0, 29) == 0) rsp_quiet = !rsp_quiet;
         rsp_hold = rsp_quiet ? 0 : $urandom_range(0, 11);
      end else if (rsp_hold > 0) begin
         rsp_hold--;
      end
      rsp_stall <= (rsp_hold != 0);
   end

   // watchdog
   int cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("size_aware_lru_admission verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   task automatic write_capacity(logic [31:0] v);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= ADDR_CAP; pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      cap_mb = v[CAP_W-1:0];
   endtask

   task automatic queue_word(logic [1:0] f, logic [TAG_W-1:0] tag, logic [BYTES_W-1:0] b,
                             logic [TIME_W-1:0] t);
      req_word_type w;
      w.func = f; w.tag = tag; w.bytes = b; w.stamp = t;
      pending_words.push_back(w);
   endtask

   // wait until everything sent has been answered, then let the block settle
   task automatic drain();
      @(negedge clock);
      while (pending_words.size() != 0 || req_valid || due_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   function automatic logic [BYTES_W-1:0] mb_bytes(longint mb);
      return {SIZE_W'(mb), 20'($urandom_range(0, 20'hFFFFF))};
   endfunction

   logic [TIME_W-1:0] now_s;

   // mostly well-formed admits with a rolling clock; some adds, touches, noise
   task automatic queue_random(int n);
      int                pick;
      logic [1:0]        f;
      logic [TAG_W-1:0]  tag;
      logic [BYTES_W-1:0] b;
      logic [TIME_W-1:0] t;
      longint            top;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(0, 99);
         f = pick < 55 ? FN_ADMIT : pick < 75 ? FN_ADD : pick < 96 ? FN_TOUCH : FN_RSVD;
         tag = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'(16'h20 + $urandom_range(0, 11));
         top = cap_mb / 3 + 1;
         if (top > 1048575) top = 1048575;
         pick = $urandom_range(0, 19);
         if (pick == 0) b = {8'($urandom), 32'($urandom)};
         else if (pick == 1) b = mb_bytes(cap_mb + 1 > 1048575 ? 1048575 : cap_mb + 1);
         else b = mb_bytes($urandom_range(0, 32'(top)));
         now_s += $urandom_range(0, 3);
         if (f == FN_ADMIT) t = now_s;
         else t = now_s + $urandom_range(0, 3) - 2;
         if ($urandom_range(0, 24) == 0) t = $urandom;
         queue_word(f, tag, b, t);
      end
   endtask

   initial begin
      errors = 0;
      used_total = 0;
      cap_mb = CAP_RESET;
      now_s = 100;
      for (int i = 0; i < SLOTS; i++) tbl_live[i] = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset capacity
      @(negedge clock);
      queue_word(FN_TOUCH, 16'h0000, '0, 32'd1);                  // touch on empty table
      queue_word(FN_RSVD, 16'hFFFF, '1, '1);                      // dropped code
      queue_word(FN_ADMIT, 16'hFFFF, '0, 32'd0);                  // zero size
      queue_word(FN_ADMIT, 16'h0001, '1, 32'd0);                  // larger than capacity
      queue_word(FN_ADMIT, 16'h0001, {20'd9999, 20'hFFFFF}, 32'd5); // exactly fills
      queue_word(FN_ADD, 16'h0002, {20'd3, 20'h0}, '1);           // overcommit, far future
      queue_word(FN_ADMIT, 16'h0003, {20'd10, 20'h0}, 32'd10);    // evicts two
      queue_word(FN_TOUCH, 16'h0002, '0, 32'd0);
      queue_word(FN_ADMIT, 16'h0004, {20'd9999, 20'h0}, 32'd0);   // runs out of victims
      // ties on time and size; the entry at now+1 must survive
      queue_word(FN_ADD, 16'h0005, {20'd1, 20'h0}, 32'd7);
      queue_word(FN_ADD, 16'h0006, {20'd1, 20'h0}, 32'd7);
      queue_word(FN_ADD, 16'h0007, {20'd0, 20'h0}, 32'd7);
      queue_word(FN_ADD, 16'h0008, {20'd1, 20'h0}, 32'd8);
      queue_word(FN_ADMIT, 16'h0009, {20'd9999, 20'h0}, 32'd7);
      // add nine entries with a duplicate tag; the table keeps free slots
      for (int i = 0; i < 9; i++) queue_word(FN_ADD, 16'h0F0F, '0, 32'(i));
      queue_word(FN_TOUCH, 16'h0F0F, '0, 32'd50);                 // lowest slot only
      queue_word(FN_ADMIT, 16'h000A, '0, 32'd0);                  // fits and a slot is free
      drain();

      // capacity 100, with a full pause halfway through
      write_capacity(32'd100);
      queue_random(32);
      drain();
      queue_random(32);
      drain();

      write_capacity(32'd0);
      queue_random(60);
      drain();
      write_capacity(32'd1048575);
      queue_random(60);
      drain();
      write_capacity(32'd37);
      queue_random(56);
      drain();
      write_capacity(32'd1);
      queue_random(56);
      drain();

      repeat (200) @(posedge clock);
      errors += due_results.size();
      if (errors == 0) begin
         $display("size_aware_lru_admission verification clean");
      end else begin
         $display("size_aware_lru_admission verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/sla_pkg.sv
src/sla_entry_mem.sv
src/size_aware_lru_admission.sv
src/sla_checker.sv
tb/tb_top.sv
